>>> sv/cfr_pkg.sv
`timescale 1ns / 1ps
package cfr_pkg;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_ROT,
        CELL_DROP,
        CELL_INS,
        CELL_MOD
    } t_cell_op;

    localparam logic [2:0] FUNC_INSERT = 3'd0;
    localparam logic [2:0] FUNC_FREE   = 3'd1;
    localparam logic [2:0] FUNC_TOUCH  = 3'd2;
    localparam logic [2:0] FUNC_PIN    = 3'd3;
    localparam logic [2:0] FUNC_UNPIN  = 3'd4;
    localparam logic [2:0] FUNC_EVICT  = 3'd5;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd1;
    localparam logic [2:0] ST_FULL       = 3'd2;
    localparam logic [2:0] ST_EMPTY      = 3'd3;
    localparam logic [2:0] ST_ALL_PINNED = 3'd4;

    localparam logic [1:0] WB_DISCARD = 2'd0;
    localparam logic [1:0] WB_FILE    = 2'd1;
    localparam logic [1:0] WB_SWAP    = 2'd2;

    localparam int PIN_BIT  = 0;
    localparam int DIRTY_BIT = 1;
    localparam int ACC_BIT  = 2;
    localparam int BACK_BIT = 3;
    localparam int FLAG_BITS = 4;

endpackage

>>> sv/cfr_cell.sv
`timescale 1ns / 1ps
module cfr_cell #(
    parameter int W   = 34,
    parameter int CW  = 7,
    parameter int IDX = 0
) (
    input  logic              i_clk,
    input  cfr_pkg::t_cell_op i_op,
    input  logic [CW-1:0]     i_count,
    input  logic [W-1:0]      i_next,
    input  logic [W-1:0]      i_head,
    input  logic [W-1:0]      i_ins,
    output logic [W-1:0]      o_entry
);

    localparam logic [CW-1:0] POS = CW'(IDX);
    localparam logic [CW-1:0] NXT = CW'(IDX + 1);

    logic [W-1:0] r_entry;

    always_ff @(posedge i_clk) begin
        case (i_op)
            cfr_pkg::CELL_ROT: begin
                if (i_count == NXT) begin
                    r_entry <= i_head;
                end else if (NXT < i_count) begin
                    r_entry <= i_next;
                end
            end
            cfr_pkg::CELL_DROP: begin
                if (NXT < i_count) begin
                    r_entry <= i_next;
                end
            end
            cfr_pkg::CELL_INS: begin
                if (i_count == POS) begin
                    r_entry <= i_ins;
                end
            end
            cfr_pkg::CELL_MOD: begin
                if (IDX == 0) begin
                    r_entry <= i_head;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_entry = r_entry;

endmodule

>>> sv/clock_frame_replacement_core.sv
// Insert, unknown codes and evict on an empty table go from accept straight to the finish state.
// Lookups rotate the cell ring to the match and back before the result is registered.
// Evict aligns to the hand, probes up to 2 x count entries, then realigns.
// One request at a time; a stalled result holds the final state until it is taken.
// Reset (synchronous, active low) empties the table and homes the hand; entries are not cleared.
`timescale 1ns / 1ps
module clock_frame_replacement_core #(
    parameter int NUM_FRAMES = 64,
    parameter int FRAME_BITS = 10,
    parameter int PAGE_BITS  = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [2:0]            i_func,
    input  logic [FRAME_BITS-1:0] i_frame_number,
    input  logic [PAGE_BITS-1:0]  i_page_number,
    input  logic                  i_backing_writable,
    input  logic                  i_is_write,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [2:0]            o_status,
    output logic [FRAME_BITS-1:0] o_victim_frame,
    output logic [PAGE_BITS-1:0]  o_victim_page,
    output logic [1:0]            o_writeback_kind
);

    localparam int W  = FRAME_BITS + PAGE_BITS + cfr_pkg::FLAG_BITS;
    localparam int CW = $clog2(NUM_FRAMES + 1);
    localparam int HW = $clog2(NUM_FRAMES);
    localparam int PW = CW + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_ALIGN, S_PROBE, S_REALIGN, S_FIN
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [HW-1:0]         r_hand, n_hand;
    logic [HW-1:0]         r_rot, n_rot;
    logic [PW-1:0]         r_probes, n_probes;
    logic [2:0]            r_func, n_func;
    logic [FRAME_BITS-1:0] r_frame, n_frame;
    logic [PAGE_BITS-1:0]  r_page, n_page;
    logic                  r_wr, n_wr;
    logic [2:0]            r_status, n_status;
    logic [FRAME_BITS-1:0] r_vframe, n_vframe;
    logic [PAGE_BITS-1:0]  r_vpage, n_vpage;
    logic [1:0]            r_kind, n_kind;
    logic                  r_o_valid, n_o_valid;
    logic [2:0]            r_o_status, n_o_status;
    logic [FRAME_BITS-1:0] r_o_vframe, n_o_vframe;
    logic [PAGE_BITS-1:0]  r_o_vpage, n_o_vpage;
    logic [1:0]            r_o_kind, n_o_kind;

    cfr_pkg::t_cell_op     cell_op;
    logic [W-1:0]          entry [NUM_FRAMES];
    logic [W-1:0]          head;
    logic [W-1:0]          head_new;
    logic [W-1:0]          ins;
    logic [FRAME_BITS-1:0] head_frame;
    logic [PAGE_BITS-1:0]  head_page;
    logic [HW-1:0]         rot_wrap;
    logic [CW-1:0]         cnt_dec;
    logic [HW-1:0]         hand_dec;
    logic                  match;
    logic                  accept;

    genvar g;
    generate
        for (g = 0; g < NUM_FRAMES; g++) begin : g_cell
            logic [W-1:0] nxt;
            if (g == NUM_FRAMES - 1) begin : g_last
                assign nxt = '0;
            end else begin : g_mid
                assign nxt = entry[g+1];
            end
            cfr_cell #(.W(W), .CW(CW), .IDX(g)) u_cell (
                .i_clk   (i_clk),
                .i_op    (cell_op),
                .i_count (r_count),
                .i_next  (nxt),
                .i_head  (head_new),
                .i_ins   (ins),
                .o_entry (entry[g])
            );
        end
    endgenerate

    assign head       = entry[0];
    assign head_frame = head[W-1 -: FRAME_BITS];
    assign head_page  = head[PAGE_BITS+cfr_pkg::FLAG_BITS-1 : cfr_pkg::FLAG_BITS];
    assign ins        = {i_frame_number, i_page_number, i_backing_writable, 3'b000};
    assign accept     = i_valid && (r_state == S_IDLE);
    assign o_stall    = (r_state != S_IDLE);
    assign rot_wrap   = ((CW'(r_rot) + CW'(1)) == r_count) ? '0 : r_rot + HW'(1);
    assign cnt_dec    = r_count - CW'(1);
    assign hand_dec   = (r_rot < r_hand) ? r_hand - HW'(1) : r_hand;
    assign match      = (r_func == cfr_pkg::FUNC_FREE) ? (head_frame == r_frame)
                                                       : (head_page == r_page);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_hand     = r_hand;
        n_rot      = r_rot;
        n_probes   = r_probes;
        n_func     = r_func;
        n_frame    = r_frame;
        n_page     = r_page;
        n_wr       = r_wr;
        n_status   = r_status;
        n_vframe   = r_vframe;
        n_vpage    = r_vpage;
        n_kind     = r_kind;
        n_o_valid  = r_o_valid;
        n_o_status = r_o_status;
        n_o_vframe = r_o_vframe;
        n_o_vpage  = r_o_vpage;
        n_o_kind   = r_o_kind;
        cell_op    = cfr_pkg::CELL_HOLD;
        head_new   = head;

        if (r_o_valid && !i_stall) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_func   = i_func;
                    n_frame  = i_frame_number;
                    n_page   = i_page_number;
                    n_wr     = i_is_write;
                    n_status = cfr_pkg::ST_OK;
                    n_vframe = '0;
                    n_vpage  = '0;
                    n_kind   = cfr_pkg::WB_DISCARD;
                    n_rot    = '0;
                    n_probes = '0;
                    n_state  = S_FIN;
                    case (i_func)
                        cfr_pkg::FUNC_INSERT: begin
                            if (r_count == CW'(NUM_FRAMES)) begin
                                n_status = cfr_pkg::ST_FULL;
                            end else begin
                                cell_op = cfr_pkg::CELL_INS;
                                n_count = r_count + CW'(1);
                                if (r_count == '0) begin
                                    n_hand = '0;
                                end
                            end
                        end
                        cfr_pkg::FUNC_FREE, cfr_pkg::FUNC_TOUCH,
                        cfr_pkg::FUNC_PIN, cfr_pkg::FUNC_UNPIN: begin
                            if (r_count == '0) begin
                                n_status = cfr_pkg::ST_NOT_FOUND;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        cfr_pkg::FUNC_EVICT: begin
                            if (r_count == '0) begin
                                n_status = cfr_pkg::ST_EMPTY;
                            end else begin
                                n_state = S_ALIGN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (match) begin
                    n_state = S_REALIGN;
                    case (r_func)
                        cfr_pkg::FUNC_FREE: begin
                            cell_op = cfr_pkg::CELL_DROP;
                            n_count = cnt_dec;
                            n_hand  = (CW'(hand_dec) >= cnt_dec) ? '0 : hand_dec;
                            n_rot   = (CW'(r_rot) >= cnt_dec) ? '0 : r_rot;
                        end
                        cfr_pkg::FUNC_TOUCH: begin
                            cell_op = cfr_pkg::CELL_MOD;
                            head_new[cfr_pkg::ACC_BIT] = 1'b1;
                            if (r_wr) begin
                                head_new[cfr_pkg::DIRTY_BIT] = 1'b1;
                            end
                        end
                        default: begin
                            cell_op = cfr_pkg::CELL_MOD;
                            head_new[cfr_pkg::PIN_BIT] = (r_func == cfr_pkg::FUNC_PIN);
                        end
                    endcase
                end else begin
                    cell_op = cfr_pkg::CELL_ROT;
                    n_rot   = rot_wrap;
                    if (rot_wrap == '0) begin
                        n_status = cfr_pkg::ST_NOT_FOUND;
                        n_state  = S_FIN;
                    end
                end
            end
            S_ALIGN: begin
                if (r_rot == r_hand) begin
                    n_state = S_PROBE;
                end else begin
                    cell_op = cfr_pkg::CELL_ROT;
                    n_rot   = rot_wrap;
                end
            end
            S_PROBE: begin
                if (r_probes == (PW'(r_count) << 1)) begin
                    n_status = cfr_pkg::ST_ALL_PINNED;
                    n_state  = S_REALIGN;
                end else begin
                    n_probes = r_probes + PW'(1);
                    if (head[cfr_pkg::PIN_BIT] || head[cfr_pkg::ACC_BIT]) begin
                        cell_op = cfr_pkg::CELL_ROT;
                        head_new[cfr_pkg::ACC_BIT] = head[cfr_pkg::ACC_BIT]
                                                     && head[cfr_pkg::PIN_BIT];
                        n_rot  = rot_wrap;
                        n_hand = rot_wrap;
                    end else begin
                        cell_op  = cfr_pkg::CELL_DROP;
                        n_vframe = head_frame;
                        n_vpage  = head_page;
                        n_kind   = !head[cfr_pkg::DIRTY_BIT] ? cfr_pkg::WB_DISCARD :
                                   head[cfr_pkg::BACK_BIT] ? cfr_pkg::WB_FILE :
                                   cfr_pkg::WB_SWAP;
                        n_count  = cnt_dec;
                        n_hand   = (CW'(r_hand) >= cnt_dec) ? '0 : r_hand;
                        n_rot    = (CW'(r_hand) >= cnt_dec) ? '0 : r_hand;
                        n_state  = S_REALIGN;
                    end
                end
            end
            S_REALIGN: begin
                if (r_rot == '0) begin
                    n_state = S_FIN;
                end else begin
                    cell_op = cfr_pkg::CELL_ROT;
                    n_rot   = rot_wrap;
                end
            end
            S_FIN: begin
                if (!r_o_valid || !i_stall) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_status;
                    n_o_vframe = r_vframe;
                    n_o_vpage  = r_vpage;
                    n_o_kind   = r_kind;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_hand    <= '0;
            r_rot     <= '0;
            r_probes  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_hand    <= n_hand;
            r_rot     <= n_rot;
            r_probes  <= n_probes;
            r_o_valid <= n_o_valid;
        end
        r_func     <= n_func;
        r_frame    <= n_frame;
        r_page     <= n_page;
        r_wr       <= n_wr;
        r_status   <= n_status;
        r_vframe   <= n_vframe;
        r_vpage    <= n_vpage;
        r_kind     <= n_kind;
        r_o_status <= n_o_status;
        r_o_vframe <= n_o_vframe;
        r_o_vpage  <= n_o_vpage;
        r_o_kind   <= n_o_kind;
    end

    assign o_valid          = r_o_valid;
    assign o_status         = r_o_status;
    assign o_victim_frame   = r_o_vframe;
    assign o_victim_page    = r_o_vpage;
    assign o_writeback_kind = r_o_kind;

endmodule

>>> sv/cfr_checker.sv
`timescale 1ns / 1ps
module cfr_checker #(
    parameter int FRAME_BITS = 10,
    parameter int PAGE_BITS  = 20
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [2:0]            o_status,
    input logic [FRAME_BITS-1:0] o_victim_frame,
    input logic [PAGE_BITS-1:0]  o_victim_page,
    input logic [1:0]            o_writeback_kind
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_victim_frame))
        else $error("stalled result changed");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != cfr_pkg::ST_OK |->
            o_victim_frame == '0 && o_victim_page == '0 && o_writeback_kind == '0)
        else $error("failed request carries a victim");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_writeback_kind != 2'd3 && o_status <= cfr_pkg::ST_ALL_PINNED)
        else $error("bad status or write-back kind");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind clock_frame_replacement_core cfr_checker #(
    .FRAME_BITS(FRAME_BITS),
    .PAGE_BITS (PAGE_BITS)
) u_cfr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_status         (o_status),
    .o_victim_frame   (o_victim_frame),
    .o_victim_page    (o_victim_page),
    .o_writeback_kind (o_writeback_kind)
);

>>> tb/sv/clock_frame_replacement_core_tb.sv
`timescale 1ns / 1ps
module clock_frame_replacement_core_tb;

    localparam int NF = 64;

    typedef struct {
        logic [2:0]  status;
        logic [9:0]  vframe;
        logic [19:0] vpage;
        logic [1:0]  kind;
    } t_outcome;

    typedef struct {
        logic [9:0]  frame;
        logic [19:0] page;
        logic        backing;
        logic        accessed;
        logic        dirty;
        logic        pinned;
    } t_slot;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_func;
    logic [9:0]  i_frame_number;
    logic [19:0] i_page_number;
    logic        i_backing_writable;
    logic        i_is_write;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_status;
    logic [9:0]  o_victim_frame;
    logic [19:0] o_victim_page;
    logic [1:0]  o_writeback_kind;

    t_slot    table_q[$];
    int       hand;
    t_outcome pending_q[$];
    int       errors;
    int       results_seen;
    int       send_idle_pct;
    int       recv_stall_pct;
    logic [9:0]  used_frames[$];
    logic [19:0] used_pages[$];

    clock_frame_replacement_core uut (.*);

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int find_page_idx(logic [19:0] p);
        foreach (table_q[k])
            if (table_q[k].page == p)
                return k;
        return -1;
    endfunction

    function automatic void drop_slot(int idx);
        table_q.delete(idx);
        if (idx < hand)
            hand--;
        if (hand >= table_q.size())
            hand = 0;
    endfunction

    function automatic t_outcome predict_table(logic [2:0] f, logic [9:0] fr, logic [19:0] pg,
                                               logic bw, logic wr);
        t_outcome o;
        t_slot s;
        int idx;
        int lim;
        bit found;
        o = '{cfr_pkg::ST_OK, '0, '0, cfr_pkg::WB_DISCARD};
        case (f)
            cfr_pkg::FUNC_INSERT: begin
                if (table_q.size() >= NF) begin
                    o.status = cfr_pkg::ST_FULL;
                end else begin
                    s = '{fr, pg, bw, 1'b0, 1'b0, 1'b0};
                    if (table_q.size() == 0)
                        hand = 0;
                    table_q.push_back(s);
                end
            end
            cfr_pkg::FUNC_FREE: begin
                idx = -1;
                foreach (table_q[k])
                    if (idx < 0 && table_q[k].frame == fr)
                        idx = k;
                if (idx < 0)
                    o.status = cfr_pkg::ST_NOT_FOUND;
                else
                    drop_slot(idx);
            end
            cfr_pkg::FUNC_TOUCH, cfr_pkg::FUNC_PIN, cfr_pkg::FUNC_UNPIN: begin
                idx = find_page_idx(pg);
                if (idx < 0) begin
                    o.status = cfr_pkg::ST_NOT_FOUND;
                end else if (f == cfr_pkg::FUNC_TOUCH) begin
                    table_q[idx].accessed = 1'b1;
                    if (wr)
                        table_q[idx].dirty = 1'b1;
                end else begin
                    table_q[idx].pinned = (f == cfr_pkg::FUNC_PIN);
                end
            end
            cfr_pkg::FUNC_EVICT: begin
                if (table_q.size() == 0) begin
                    o.status = cfr_pkg::ST_EMPTY;
                end else begin
                    lim = 2 * table_q.size();
                    found = 0;
                    for (int n = 0; n < lim && !found; n++) begin
                        if (hand >= table_q.size())
                            hand = 0;
                        if (table_q[hand].pinned) begin
                            hand = (hand + 1 >= table_q.size()) ? 0 : hand + 1;
                        end else if (table_q[hand].accessed) begin
                            table_q[hand].accessed = 1'b0;
                            hand = (hand + 1 >= table_q.size()) ? 0 : hand + 1;
                        end else begin
                            o.vframe = table_q[hand].frame;
                            o.vpage = table_q[hand].page;
                            o.kind = !table_q[hand].dirty ? cfr_pkg::WB_DISCARD
                                   : (table_q[hand].backing ? cfr_pkg::WB_FILE
                                                            : cfr_pkg::WB_SWAP);
                            drop_slot(hand);
                            found = 1;
                        end
                    end
                    if (!found)
                        o.status = cfr_pkg::ST_ALL_PINNED;
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    task automatic send_request(logic [2:0] f, logic [9:0] fr, logic [19:0] pg,
                                logic bw, logic wr);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= f;
        i_frame_number <= fr;
        i_page_number <= pg;
        i_backing_writable <= bw;
        i_is_write <= wr;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        pending_q.push_back(predict_table(f, fr, pg, bw, wr));
    endtask

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_outcome e;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (pending_q.size() == 0) begin
                $error("result with nothing expected: status %0d", o_status);
                errors++;
            end else begin
                e = pending_q.pop_front();
                if (o_status !== e.status) begin
                    $error("status expected %0d actual %0d", e.status, o_status);
                    errors++;
                end
                if (o_victim_frame !== e.vframe) begin
                    $error("victim_frame expected %0d actual %0d", e.vframe, o_victim_frame);
                    errors++;
                end
                if (o_victim_page !== e.vpage) begin
                    $error("victim_page expected %0d actual %0d", e.vpage, o_victim_page);
                    errors++;
                end
                if (o_writeback_kind !== e.kind) begin
                    $error("writeback_kind expected %0d actual %0d", e.kind, o_writeback_kind);
                    errors++;
                end
            end
        end
    end

    function automatic logic [9:0] pick_frame();
        if (used_frames.size() > 0 && $urandom_range(3) != 0)
            return used_frames[$urandom_range(used_frames.size() - 1)];
        return 10'($urandom);
    endfunction

    function automatic logic [19:0] pick_page();
        if (used_pages.size() > 0 && $urandom_range(3) != 0)
            return used_pages[$urandom_range(used_pages.size() - 1)];
        return 20'($urandom);
    endfunction

    task automatic insert_fresh(logic [9:0] fr, logic [19:0] pg, logic bw);
        used_frames.push_back(fr);
        used_pages.push_back(pg);
        send_request(cfr_pkg::FUNC_INSERT, fr, pg, bw, 1'b0);
    endtask

    task automatic test_directed();
        send_request(cfr_pkg::FUNC_EVICT, '0, '0, 1'b0, 1'b0);
        send_request(cfr_pkg::FUNC_FREE, 10'h3ff, '0, 1'b0, 1'b0);
        send_request(cfr_pkg::FUNC_TOUCH, '0, 20'hfffff, 1'b1, 1'b1);
        insert_fresh(10'h000, 20'h00000, 1'b0);
        insert_fresh(10'h3ff, 20'hfffff, 1'b1);
        insert_fresh(10'h155, 20'haaaaa, 1'b1);
        send_request(cfr_pkg::FUNC_TOUCH, '0, 20'hfffff, 1'b0, 1'b1);
        send_request(cfr_pkg::FUNC_TOUCH, '0, 20'haaaaa, 1'b0, 1'b0);
        send_request(cfr_pkg::FUNC_PIN, '0, 20'h00000, 1'b0, 1'b0);
        send_request(cfr_pkg::FUNC_PIN, '0, 20'h00000, 1'b0, 1'b0);
        send_request(cfr_pkg::FUNC_UNPIN, '0, 20'h55555, 1'b0, 1'b0);
        send_request(cfr_pkg::FUNC_EVICT, '0, '0, 1'b0, 1'b0);
        send_request(cfr_pkg::FUNC_EVICT, '0, '0, 1'b0, 1'b0);
        send_request(3'd6, 10'h3ff, 20'hfffff, 1'b1, 1'b1);
        send_request(3'd7, '0, '0, 1'b0, 1'b0);
        send_request(cfr_pkg::FUNC_EVICT, '0, '0, 1'b0, 1'b0);
        send_request(cfr_pkg::FUNC_UNPIN, '0, 20'h00000, 1'b0, 1'b0);
        send_request(cfr_pkg::FUNC_UNPIN, '0, 20'h00000, 1'b0, 1'b0);
        insert_fresh(10'h000, 20'h12345, 1'b0);
        send_request(cfr_pkg::FUNC_FREE, 10'h000, '0, 1'b0, 1'b0);
        send_request(cfr_pkg::FUNC_FREE, 10'h000, '0, 1'b0, 1'b0);
        send_request(cfr_pkg::FUNC_EVICT, '0, '0, 1'b0, 1'b0);
    endtask

    task automatic test_full_table();
        while (table_q.size() < NF)
            insert_fresh(10'($urandom), 20'($urandom), 1'($urandom));
        send_request(cfr_pkg::FUNC_INSERT, 10'h3ff, 20'hfffff, 1'b1, 1'b0);
        foreach (used_pages[k])
            send_request(cfr_pkg::FUNC_PIN, '0, used_pages[k], 1'b0, 1'b0);
        send_request(cfr_pkg::FUNC_EVICT, '0, '0, 1'b0, 1'b0);
        send_request(cfr_pkg::FUNC_UNPIN, '0, table_q[NF-1].page, 1'b0, 1'b0);
        send_request(cfr_pkg::FUNC_EVICT, '0, '0, 1'b0, 1'b0);
        while (table_q.size() > 0)
            send_request(cfr_pkg::FUNC_FREE, table_q[$urandom_range(table_q.size() - 1)].frame,
                         '0, 1'b0, 1'b0);
        used_frames.delete();
        used_pages.delete();
    endtask

    task automatic test_random(int n);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 25 && table_q.size() < 20)
                insert_fresh(($urandom_range(3) == 0) ? pick_frame() : 10'($urandom),
                             ($urandom_range(3) == 0) ? pick_page() : 20'($urandom),
                             1'($urandom));
            else if (r < 45)
                send_request(cfr_pkg::FUNC_TOUCH, 10'($urandom), pick_page(), 1'($urandom),
                             1'($urandom));
            else if (r < 55)
                send_request(cfr_pkg::FUNC_PIN, 10'($urandom), pick_page(), 1'($urandom),
                             1'($urandom));
            else if (r < 63)
                send_request(cfr_pkg::FUNC_UNPIN, 10'($urandom), pick_page(), 1'($urandom),
                             1'($urandom));
            else if (r < 72)
                send_request(cfr_pkg::FUNC_FREE, pick_frame(), 20'($urandom), 1'($urandom),
                             1'($urandom));
            else if (r < 97)
                send_request(cfr_pkg::FUNC_EVICT, 10'($urandom), 20'($urandom), 1'($urandom),
                             1'($urandom));
            else
                send_request(3'($urandom_range(7, 6)), 10'($urandom), 20'($urandom),
                             1'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        errors = 0;
        results_seen = 0;
        hand = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_func = '0;
        i_frame_number = '0;
        i_page_number = '0;
        i_backing_writable = 1'b0;
        i_is_write = 1'b0;
        i_stall = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_table();
        test_random(150);
        send_idle_pct = 70;
        test_random(150);
        send_idle_pct = 0;
        recv_stall_pct = 70;
        test_random(150);
        send_idle_pct = 37;
        recv_stall_pct = 37;
        test_random(150);
        i_valid <= 1'b0;
        recv_stall_pct = 0;
        while (pending_q.size() > 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("Covered all request codes, full, empty and all-pinned tables, %0d results.",
                 results_seen);
        if (errors == 0 && pending_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
